>>> hdl/cram_pkg.sv
// Shared constants and types for the 2x2 Cramer's rule solver.
package cram_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [1:0] {
		ST_SOLVED   = 2'd0,
		ST_SINGULAR = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> hdl/cram_front.sv
// Front end: takes words, forms determinant and numerators, classifies singular systems.
module cram_front import cram_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [WORD_BITS-1:0]   m11,
	input  logic signed [WORD_BITS-1:0]   m12,
	input  logic signed [WORD_BITS-1:0]   m21,
	input  logic signed [WORD_BITS-1:0]   m22,
	input  logic signed [WORD_BITS-1:0]   rhs1,
	input  logic signed [WORD_BITS-1:0]   rhs2,
	output logic                          q_push,
	output logic [6*WORD_BITS+3:0]        q_data,
	input  qstat_t                        q_stat
);

	localparam int MW = 2 * WORD_BITS;

	logic v_s1, v_s2, v_s3;
	logic adv;

	logic signed [MW-1:0] pad_s1, pbc_s1, pr1d_s1, pr2b_s1, par2_s1, pr1c_s1;
	logic signed [MW:0]   det_s2, n1_s2, n2_s2;
	logic [MW-1:0]        dmag_s3, n1mag_s3, n2mag_s3;
	logic                 dneg_s3, n1neg_s3, n2neg_s3, sing_s3;

	assign adv    = !(v_s3 && q_stat.full);
	assign full   = !adv;
	assign q_push = v_s3 && !q_stat.full;
	assign q_data = {sing_s3, dneg_s3, n1neg_s3, n2neg_s3, dmag_s3, n1mag_s3, n2mag_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pad_s1   <= MW'(m11) * MW'(m22);
			pbc_s1   <= MW'(m12) * MW'(m21);
			pr1d_s1  <= MW'(rhs1) * MW'(m22);
			pr2b_s1  <= MW'(rhs2) * MW'(m12);
			par2_s1  <= MW'(m11) * MW'(rhs2);
			pr1c_s1  <= MW'(rhs1) * MW'(m21);
			det_s2   <= (MW+1)'(pad_s1) - (MW+1)'(pbc_s1);
			n1_s2    <= (MW+1)'(pr1d_s1) - (MW+1)'(pr2b_s1);
			n2_s2    <= (MW+1)'(par2_s1) - (MW+1)'(pr1c_s1);
			dneg_s3  <= det_s2[MW];
			n1neg_s3 <= n1_s2[MW];
			n2neg_s3 <= n2_s2[MW];
			dmag_s3  <= MW'(det_s2[MW] ? -det_s2 : det_s2);
			n1mag_s3 <= MW'(n1_s2[MW] ? -n1_s2 : n1_s2);
			n2mag_s3 <= MW'(n2_s2[MW] ? -n2_s2 : n2_s2);
			sing_s3  <= (det_s2 == '0);
		end
	end

endmodule

>>> hdl/cram_queue.sv
// Short queue between the front end and the divider.
module cram_queue import cram_pkg::*; #(
	parameter int WIDTH = 6 * WORD_BITS_DEF + 4,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output qstat_t           stat
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [AW:0]      cnt_q;

	assign rd_data    = mem_q[rptr_q];
	assign stat.full  = (cnt_q == (AW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= rptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_data;
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!stat.full || rd_en)) else $error("word written into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !stat.empty) else $error("word read from empty queue");

endmodule

>>> hdl/cram_back.sv
// Back end: pipelined restoring division, range check and result register.
module cram_back import cram_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [6*WORD_BITS+3:0]      q_data,
	input  qstat_t                      q_stat,
	output logic                        q_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [WORD_BITS-1:0] sol1,
	output logic signed [WORD_BITS-1:0] sol2,
	output logic [1:0]                  status
);

	localparam int W    = WORD_BITS;
	localparam int MW   = 2 * W;
	localparam int NW   = MW + FRAC_BITS;
	localparam int CW   = (NW > 3 * W) ? NW : 3 * W;
	localparam int LAST = W + 1;

	logic adv;

	logic          q_sing, q_dneg;
	logic [1:0]    q_nneg;
	logic [MW-1:0] q_dmag;
	logic [MW-1:0] q_nmag [0:1];

	logic          v_s0, sing_s0;
	logic [MW-1:0] dmag_s0;
	logic [MW-1:0] nmag_s0 [0:1];
	logic          neg_s0  [0:1];

	logic          v_s    [1:LAST];
	logic          sing_s [1:LAST];
	logic [MW-1:0] dmag_s [1:LAST];
	logic [MW-1:0] rem_s  [1:LAST][0:1];
	logic [W-1:0]  low_s  [1:LAST][0:1];
	logic [W-1:0]  quo_s  [1:LAST][0:1];
	logic          ovf_s  [1:LAST][0:1];
	logic          neg_s  [1:LAST][0:1];

	logic          out_v_q;
	logic [W-1:0]  sol1_q, sol2_q;
	status_t       status_q;

	logic [W-1:0]  word  [0:1];
	logic          bad   [0:1];
	status_t       st_next;
	logic [W-1:0]  sol1_next, sol2_next;

	assign {q_sing, q_dneg, q_nneg[0], q_nneg[1], q_dmag, q_nmag[0], q_nmag[1]} = q_data;

	assign adv    = !out_v_q || pop;
	assign q_pop  = adv && !q_stat.empty;
	assign empty  = !out_v_q;
	assign sol1   = sol1_q;
	assign sol2   = sol2_q;
	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 1; k <= LAST; k++)
				v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s0    <= q_pop;
			v_s[1]  <= v_s0;
			for (int k = 2; k <= LAST; k++)
				v_s[k] <= v_s[k-1];
			out_v_q <= v_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_s0 <= q_sing;
			dmag_s0 <= q_dmag;
			for (int l = 0; l < 2; l++) begin
				nmag_s0[l] <= q_nmag[l];
				neg_s0[l]  <= q_nneg[l] ^ q_dneg;
			end
		end
	end

	generate
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [CW-1:0] nw, dw;

			assign nw = CW'(nmag_s0[l]) << FRAC_BITS;
			assign dw = CW'(dmag_s0) << W;

			always_ff @(posedge clk) begin
				if (adv) begin
					ovf_s[1][l] <= (nw >= dw);
					rem_s[1][l] <= MW'(nw >> W);
					low_s[1][l] <= nw[W-1:0];
					quo_s[1][l] <= '0;
					neg_s[1][l] <= neg_s0[l];
				end
			end

			for (genvar k = 2; k <= LAST; k++) begin : g_step
				logic [MW:0] trial, diff;
				logic        ge;

				assign trial = {rem_s[k-1][l], low_s[k-1][l][W-1]};
				assign diff  = trial - {1'b0, dmag_s[k-1]};
				assign ge    = (trial >= {1'b0, dmag_s[k-1]});

				always_ff @(posedge clk) begin
					if (adv) begin
						rem_s[k][l] <= ge ? diff[MW-1:0] : trial[MW-1:0];
						low_s[k][l] <= low_s[k-1][l] << 1;
						quo_s[k][l] <= {quo_s[k-1][l][W-2:0], ge};
						ovf_s[k][l] <= ovf_s[k-1][l];
						neg_s[k][l] <= neg_s[k-1][l];
					end
				end
			end

			assign word[l] = neg_s[LAST][l] ? -quo_s[LAST][l] : quo_s[LAST][l];
			assign bad[l]  = ovf_s[LAST][l] ||
				(neg_s[LAST][l] ? (quo_s[LAST][l][W-1] && (quo_s[LAST][l][W-2:0] != '0))
					: quo_s[LAST][l][W-1]);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_s[1] <= sing_s0;
			dmag_s[1] <= dmag_s0;
			for (int k = 2; k <= LAST; k++) begin
				sing_s[k] <= sing_s[k-1];
				dmag_s[k] <= dmag_s[k-1];
			end
		end
	end

	always_comb begin
		st_next   = ST_SOLVED;
		sol1_next = '0;
		sol2_next = '0;
		priority if (sing_s[LAST]) begin
			st_next = ST_SINGULAR;
		end else if (bad[0] || bad[1]) begin
			st_next = ST_RANGE;
		end else begin
			sol1_next = word[0];
			sol2_next = word[1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sol1_q   <= sol1_next;
			sol2_q   <= sol2_next;
			status_q <= st_next;
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q != ST_SOLVED) |-> (sol1_q == '0 && sol2_q == '0))
		else $error("failed word carries nonzero solution");
	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[LAST] && sing_s[LAST]) |-> (dmag_s[LAST] == '0))
		else $error("singular flag lost its determinant");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[1] && !sing_s[1] && !ovf_s[1][0]) |-> (rem_s[1][0] < dmag_s[1]))
		else $error("initial remainder not below divisor");

endmodule

>>> hdl/cramer_solver_2x2.sv
// Top level of the 2x2 Cramer's rule solver.
// Solves [m11 m12; m21 m22] x = [rhs1; rhs2] in signed fixed point (default Q16.16) and returns
// sol1, sol2 truncated toward zero with status 0 solved, 1 singular, 2 out of range (solutions
// zero on failure). One word is taken per cycle while full is low and one result leaves per cycle
// while pop is held; a word passes from push to the result ports through the front end's three
// stages (products, differences, magnitudes), the four-entry queue and the divider's one
// quotient bit per stage across WORD_BITS stages.
module cramer_solver_2x2 import cram_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic signed [WORD_BITS-1:0] m11,
	input  logic signed [WORD_BITS-1:0] m12,
	input  logic signed [WORD_BITS-1:0] m21,
	input  logic signed [WORD_BITS-1:0] m22,
	input  logic signed [WORD_BITS-1:0] rhs1,
	input  logic signed [WORD_BITS-1:0] rhs2,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [WORD_BITS-1:0] sol1,
	output logic signed [WORD_BITS-1:0] sol2,
	output logic [1:0]                  status
);

	localparam int EW = 6 * WORD_BITS + 4;

	logic          wr_en, rd_en;
	logic [EW-1:0] wr_data, rd_data;
	qstat_t        q_stat;

	cram_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.m11    (m11),
		.m12    (m12),
		.m21    (m21),
		.m22    (m22),
		.rhs1   (rhs1),
		.rhs2   (rhs2),
		.q_push (wr_en),
		.q_data (wr_data),
		.q_stat (q_stat)
	);

	cram_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.stat    (q_stat)
	);

	cram_back #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (rd_data),
		.q_stat (q_stat),
		.q_pop  (rd_en),
		.empty  (empty),
		.pop    (pop),
		.sol1   (sol1),
		.sol2   (sol2),
		.status (status)
	);

endmodule

>>> tb/cram_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 2x2 Cramer solver: predicts each answer and checks every result word.
module cram_checker import cram_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        full,
	input  logic signed [WORD_BITS-1:0] m11,
	input  logic signed [WORD_BITS-1:0] m12,
	input  logic signed [WORD_BITS-1:0] m21,
	input  logic signed [WORD_BITS-1:0] m22,
	input  logic signed [WORD_BITS-1:0] rhs1,
	input  logic signed [WORD_BITS-1:0] rhs2,
	input  logic                        empty,
	input  logic                        pop,
	input  logic signed [WORD_BITS-1:0] sol1,
	input  logic signed [WORD_BITS-1:0] sol2,
	input  logic [1:0]                  status,
	output int                          errors,
	output int                          pending
);

	typedef struct {
		logic signed [WORD_BITS-1:0] x1;
		logic signed [WORD_BITS-1:0] x2;
		status_t                     st;
	} answer_t;

	answer_t answers_due[$];
	answer_t want;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic answer_t cramer_answer(
		logic signed [WORD_BITS-1:0] a11, logic signed [WORD_BITS-1:0] a12,
		logic signed [WORD_BITS-1:0] a21, logic signed [WORD_BITS-1:0] a22,
		logic signed [WORD_BITS-1:0] b1, logic signed [WORD_BITS-1:0] b2);
		logic signed [127:0] x11, x12, x21, x22, y1, y2;
		logic signed [127:0] det, num1, num2, q1, q2, lim_hi, lim_lo;
		answer_t ans;
		x11 = a11;
		x12 = a12;
		x21 = a21;
		x22 = a22;
		y1 = b1;
		y2 = b2;
		lim_hi = (128'sd1 <<< (WORD_BITS - 1)) - 128'sd1;
		lim_lo = -(128'sd1 <<< (WORD_BITS - 1));
		ans.x1 = '0;
		ans.x2 = '0;
		det = x11 * x22 - x12 * x21;
		if (det == 0) begin
			ans.st = ST_SINGULAR;
			return ans;
		end
		num1 = (y1 * x22 - y2 * x12) <<< FRAC_BITS;
		num2 = (x11 * y2 - y1 * x21) <<< FRAC_BITS;
		q1 = num1 / det;
		q2 = num2 / det;
		if (q1 > lim_hi || q1 < lim_lo || q2 > lim_hi || q2 < lim_lo) begin
			ans.st = ST_RANGE;
			return ans;
		end
		ans.x1 = q1[WORD_BITS-1:0];
		ans.x2 = q2[WORD_BITS-1:0];
		ans.st = ST_SOLVED;
		return ans;
	endfunction

	task automatic note_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (answers_due.size() == 0) begin
					note_mismatch($sformatf("result word with nothing pending: %0d %0d %0d",
						sol1, sol2, status));
				end else begin
					want = answers_due.pop_front();
					if (sol1 !== want.x1)
						note_mismatch($sformatf("sol1 got %0d expected %0d", sol1, want.x1));
					if (sol2 !== want.x2)
						note_mismatch($sformatf("sol2 got %0d expected %0d", sol2, want.x2));
					if (status !== want.st)
						note_mismatch($sformatf("status got %0d expected %0d", status, want.st));
				end
			end
			if (push && !full)
				answers_due.push_back(cramer_answer(m11, m12, m21, m22, rhs1, rhs2));
			pending = answers_due.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the 2x2 Cramer solver: drives systems, drains results, gives the verdict.
module tb;
	import cram_pkg::*;

	localparam int W = WORD_BITS_DEF;
	localparam int F = FRAC_BITS_DEF;
	localparam int N_RANDOM = 450;
	localparam logic signed [W-1:0] ONE  = 1 <<< F;
	localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic signed [W-1:0] m11 = '0, m12 = '0, m21 = '0, m22 = '0, rhs1 = '0, rhs2 = '0;
	logic full, empty;
	logic signed [W-1:0] sol1, sol2;
	logic [1:0] status;
	int errors, pending;
	bit calm = 1'b0;

	cramer_solver_2x2 #(.WORD_BITS(W), .FRAC_BITS(F)) dut (.*);

	cram_checker #(.WORD_BITS(W), .FRAC_BITS(F)) checker_i (.*);

	initial forever #1 clk = ~clk;

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic signed [W-1:0] rnd_word();
		int k;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed($urandom) >>> $urandom_range(0, W - 1);
			2: begin
				k = $urandom_range(0, 64);
				k -= 32;
				return k <<< F;
			end
			3: begin
				case ($urandom_range(0, 6))
					0: return '0;
					1: return 1;
					2: return -1;
					3: return MAXW;
					4: return MINW;
					5: return ONE;
					default: return -ONE;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [W-1:0] tiny();
		int k;
		k = $urandom_range(0, 512);
		return k - 256;
	endfunction

	// hold the word until it is taken
	task automatic send_system(logic signed [W-1:0] a11, logic signed [W-1:0] a12,
		logic signed [W-1:0] a21, logic signed [W-1:0] a22,
		logic signed [W-1:0] b1, logic signed [W-1:0] b2);
		int gap;
		bit taken;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		m11 <= a11;
		m12 <= a12;
		m21 <= a21;
		m22 <= a22;
		rhs1 <= b1;
		rhs2 <= b2;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	initial begin
		int gap;
		bit taken;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(negedge clk);
				taken = !empty;
				@(posedge clk);
			end while (!taken);
		end
	end

	initial begin
		int a, b, k, drain;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_system('0, '0, '0, '0, '0, '0);
		send_system(ONE, '0, '0, ONE, ONE * 7 / 2, -(ONE * 9 / 4));
		send_system(ONE, '0, '0, ONE, MAXW, MINW);
		send_system(MINW, MINW, MINW, MINW, ONE, ONE);
		send_system(MAXW, MAXW, MAXW, MAXW, MAXW, MINW);
		send_system(MINW, MAXW, MAXW, MINW, MAXW, MINW);
		send_system(ONE / 2, '0, '0, ONE / 2, 1 <<< 30, ONE);
		send_system(ONE / 2, '0, '0, ONE / 2, -(1 <<< 30), (1 <<< 30) - 1);
		send_system(ONE, ONE * 2, ONE * 2, ONE * 4, ONE, ONE);
		send_system(ONE * 3, '0, '0, ONE * 3, ONE, ONE);
		send_system(ONE * 3, '0, '0, ONE * 3, -ONE, -ONE * 2);
		send_system('0, ONE, ONE, '0, '0, ONE * 2);
		send_system(1, '0, '0, 1, 1, -1);
		send_system(1, '0, '0, 1, MAXW, '0);
		send_system(MINW, '0, '0, -1, MINW, 1);
		send_system(MAXW, MINW, 1, -1, MAXW, MAXW);
		send_system(-ONE, '0, '0, -ONE, ONE, -ONE);
		send_system(ONE * 5, -ONE * 3, ONE * 2, ONE * 7, '0, '0);
		send_system(1, 1, 1, 2, MINW, MAXW);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: begin
					a = $urandom_range(0, 65535);
					a -= 32768;
					b = $urandom_range(0, 65535);
					b -= 32768;
					k = $urandom_range(0, 8);
					k -= 4;
					send_system(a, b, a * k, b * k, rnd_word(), rnd_word());
				end
				1: send_system(tiny(), tiny(), tiny(), tiny(), rnd_word(), rnd_word());
				2: send_system($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				default: send_system(rnd_word(), rnd_word(), rnd_word(), rnd_word(),
					rnd_word(), rnd_word());
			endcase
		end
		push <= 1'b0;

		while (pending != 0) @(negedge clk);
		drain = W + 16;
		repeat (drain) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
